// ----- hdl/stoi_pkg.sv -----
// shared types, constants and character helpers for the string to integer parser
// no dependencies; imported by stoi_step and string_to_integer_parser
package stoi_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int VALUE_W     = 64;
    localparam int END_W       = 16;
    localparam int BASE_W      = 6;

    localparam longint unsigned OFFSET_FULL = (64'd1 << OFFSET_BITS) - 64'd1;
    localparam logic [OFFSET_BITS-1:0] OFFSET_LIMIT =
        OFFSET_BITS'((OFFSET_FULL > 64'hFFFF) ? 64'hFFFF : OFFSET_FULL);

    localparam logic [BASE_W-1:0] MAX_BASE  = 6'd36;
    localparam logic [BASE_W-1:0] NOT_DIGIT = 6'd36;
    localparam logic [BASE_W-1:0] BAD_BASE  = 6'd1;
    localparam logic [BASE_W-1:0] AUTO_BASE = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    // configuration register indexes
    localparam logic REG_NUMBER_BASE = 1'b0;
    localparam logic REG_SIGNED_MODE = 1'b1;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_START,
        PH_ZERO,
        PH_HEXPRE,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic [VALUE_W-1:0]     acc;
        logic                   neg;
        logic [BASE_W-1:0]      base;
        logic [OFFSET_BITS-1:0] pos;
        logic [OFFSET_BITS-1:0] stop;
    } parse_state_t;

    localparam parse_state_t PARSE_CLEAR = '{
        phase: PH_SKIP,
        acc:   '0,
        neg:   1'b0,
        base:  '0,
        pos:   '0,
        stop:  '0
    };

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {[8'd9:8'd13], 8'd32});
    endfunction

    function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] c);
        logic [BASE_W-1:0] d;
        d = NOT_DIGIT;
        if (c inside {[8'h30:8'h39]})
        begin
            d = BASE_W'(c - 8'h30);
        end
        else if (c inside {[8'h41:8'h5A]})
        begin
            d = BASE_W'(c - 8'h41 + 8'd10);
        end
        else if (c inside {[8'h61:8'h7A]})
        begin
            d = BASE_W'(c - 8'h61 + 8'd10);
        end
        return d;
    endfunction

endpackage

// ----- hdl/stoi_step.sv -----
// next-state logic for one character: phase walk, prefix handling, multiply-accumulate
// depends on stoi_pkg
module stoi_step (
    input  stoi_pkg::parse_state_t      cur,
    input  logic [7:0]                  character,
    input  logic [stoi_pkg::BASE_W-1:0] number_base,
    input  logic                        signed_mode,
    output stoi_pkg::parse_state_t      nxt
);
    import stoi_pkg::*;

    logic                   start_en;
    logic                   take_en;
    logic [BASE_W-1:0]      start_base;
    logic [BASE_W-1:0]      take_base;
    logic [BASE_W-1:0]      digit;
    logic [OFFSET_BITS-1:0] pos_next;
    logic [VALUE_W-1:0]     product;

    assign digit    = digit_of(character);
    assign pos_next = (cur.pos < OFFSET_LIMIT) ? cur.pos + 1'b1 : OFFSET_LIMIT;
    assign product  = cur.acc * VALUE_W'(take_base);

    always_comb
    begin
        nxt        = cur;
        start_en   = 1'b0;
        take_en    = 1'b0;
        start_base = cur.base;
        take_base  = cur.base;

        case (cur.phase)
            PH_SKIP:
            begin
                // base is latched here, out-of-range radix parks at one
                start_base = (number_base == BAD_BASE || number_base > MAX_BASE) ?
                             BAD_BASE : number_base;
                nxt.base = start_base;
                if (is_space(character))
                begin
                    nxt.phase = PH_SKIP;
                end
                else if (character == CH_PLUS)
                begin
                    nxt.phase = PH_START;
                end
                else if (character == CH_MINUS && signed_mode)
                begin
                    nxt.neg   = 1'b1;
                    nxt.phase = PH_START;
                end
                else
                begin
                    nxt.phase = PH_START;
                    start_en  = 1'b1;
                end
            end
            PH_START:
            begin
                start_en = 1'b1;
            end
            PH_ZERO:
            begin
                if (character == CH_X_LO || character == CH_X_UP)
                begin
                    nxt.base  = BASE_HEX;
                    nxt.phase = PH_HEXPRE;
                end
                else
                begin
                    take_en   = 1'b1;
                    take_base = (cur.base == AUTO_BASE) ? BASE_OCT : cur.base;
                end
            end
            PH_HEXPRE, PH_DIGITS:
            begin
                take_en = 1'b1;
            end
            default:
            begin
                nxt.phase = PH_DONE;
            end
        endcase

        if (start_en)
        begin
            if (start_base == BAD_BASE)
            begin
                nxt.phase = PH_DONE;
            end
            else if (character == CH_ZERO &&
                     (start_base == AUTO_BASE || start_base == BASE_HEX))
            begin
                nxt.stop  = pos_next;
                nxt.phase = PH_ZERO;
            end
            else
            begin
                take_en   = 1'b1;
                take_base = (start_base == AUTO_BASE) ? BASE_DEC : start_base;
            end
        end

        if (take_en)
        begin
            nxt.base = take_base;
            if (digit >= take_base)
            begin
                nxt.phase = PH_DONE;
            end
            else
            begin
                // a minus sign subtracts each digit, wrapping at the word width
                nxt.acc   = cur.neg ? product - VALUE_W'(digit) : product + VALUE_W'(digit);
                nxt.stop  = pos_next;
                nxt.phase = PH_DIGITS;
            end
        end

        nxt.pos = pos_next;
    end

endmodule

// ----- hdl/string_to_integer_parser.sv -----
// top level of the string to integer parser: input register, parse state, result register
// depends on stoi_pkg and stoi_step
//
//  channel   dir  signals                      contents
//  s_*       in   s_tvalid s_tready s_tdata    tdata[7:0] character, tlast is_last
//  m_*       out  m_tvalid m_tready m_tdata    tdata[63:0] value, tdata[79:64] end_offset
//  cfg_*     in   cfg_we cfg_index cfg_data    index 0 number_base, 1 signed_mode
//
// one character per cycle unless a last character waits on a stalled result; a request
// is held in the input register, then folded into the parse state, the 64 x 6 multiply-add
// being the longest path. a result is registered when the request marked last is folded in.
// reset clears the parse state and both valid flags; number_base returns to 10 and
// signed_mode to 1. a stalled result only blocks the input when a further last
// character is waiting behind it.
module string_to_integer_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] character
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [79:0]                 m_tdata,   // [63:0] value, [79:64] end_offset
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [stoi_pkg::BASE_W-1:0] cfg_data
);
    import stoi_pkg::*;

    logic               in_valid_reg;
    logic [7:0]         in_char_reg;
    logic               in_last_reg;
    parse_state_t       state_reg;
    parse_state_t       state_next;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [END_W-1:0]   out_end_reg;
    logic [BASE_W-1:0]  number_base_reg;
    logic               signed_mode_reg;
    logic               proc_fire;
    logic               in_accept;

    // a last character needs the result slot free (or freeing this cycle)
    assign proc_fire = in_valid_reg && !(in_last_reg && out_valid_reg && !m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign in_accept = s_tvalid && s_tready;

    stoi_step u_step (
        .cur         (state_reg),
        .character   (in_char_reg),
        .number_base (number_base_reg),
        .signed_mode (signed_mode_reg),
        .nxt         (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= BASE_DEC;
            signed_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUMBER_BASE: number_base_reg <= cfg_data;
                REG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                default:         number_base_reg <= number_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= PARSE_CLEAR;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (proc_fire && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (proc_fire)
            begin
                state_reg <= in_last_reg ? PARSE_CLEAR : state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proc_fire && in_last_reg)
        begin
            out_value_reg <= state_next.acc;
            out_end_reg   <= END_W'(state_next.stop);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_end_reg, out_value_reg};

endmodule

// ----- hdl/stoi_checker.sv -----
// port-level checks for string_to_integer_parser, attached by bind
// no package dependencies
module stoi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    // result held while the sink stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    // no result shown on the edge after one seen in reset
    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // a nonzero value always consumed at least one character
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[63:0] != 64'd0 |-> m_tdata[79:64] != 16'd0)
        else $error("nonzero value with zero end offset");

    // input only backs up behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

endmodule

bind string_to_integer_parser stoi_checker u_stoi_checker (.*);
